// ===== src/fed_pkg.sv =====
// ----------------------------------------------------------------------------
// fed_pkg: shared types and constants for the feedback echo delay
// Sample and gain widths, register map and the q16 round/saturate helper.
// ----------------------------------------------------------------------------
package fed_pkg;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int MIX_W    = 17;
    localparam int DLEN_W   = 17;

    // product and accumulator widths
    localparam int PROD_W = SAMPLE_W + MIX_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    // gain limits and register reset values
    localparam logic [GAIN_W-1:0] FB_CEIL   = 16'd62259;
    localparam logic [MIX_W-1:0]  MIX_ONE   = 17'd65536;
    localparam int                DELAY_RST = 24000;
    localparam logic [GAIN_W-1:0] FB_RST    = 16'd0;
    localparam logic [MIX_W-1:0]  MIX_RST   = 17'd32768;

    // register map, one word per register
    typedef enum logic [1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_MIX      = 2'd2
    } t_reg_idx;

    // round half up of v / 2^16, then saturate to the sample range
    function automatic logic [SAMPLE_W-1:0] q16_round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]  r;
        logic signed [ACC_W-17:0] q;
        logic signed [ACC_W-17:0] q_max;
        logic signed [ACC_W-17:0] q_min;
        q_max = (ACC_W-16)'(2**(SAMPLE_W-1) - 1);
        q_min = -q_max - (ACC_W-16)'(1);
        r = v + ACC_W'(32768);
        q = r[ACC_W-1:16];
        if (q > q_max) begin
            q = q_max;
        end else if (q < q_min) begin
            q = q_min;
        end
        return q[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== src/feedback_echo_delay.sv =====
// Data path: input request, stage 1 (read), stage 2 (multiply), output register (mix).
// Throughput: one sample per cycle unless the output stalls; a sample whose delayed
// read hits the prior sample of its channel (delay_length of one) waits for its write-back.
// Delay store sits in one single-port-read, single-port-write memory.
// Reset: no clearing pass; per-channel wrap flags make unwritten entries read zero.
// ----------------------------------------------------------------------------
// feedback_echo_delay: feedback echo with dry/wet mix
// Per-channel circular delay line in one memory, feedback write-back with
// saturation, and a q16 dry/wet mix of the delayed and incoming sample.
// ----------------------------------------------------------------------------
module feedback_echo_delay #(
    parameter int MAX_DELAY    = 131072,
    parameter int NUM_CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [23:0] sample_in
    input  logic [0:0]  i_s_axis_tuser,   // [0] chan
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [23:0] sample_out
    output logic [0:0]  o_m_axis_tuser,   // [0] chan_out
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW    = $clog2(MAX_DELAY);
    localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DEPTH = NUM_CHANNELS * MAX_DELAY;
    localparam int MW    = $clog2(DEPTH);
    localparam int LW    = (AW > fed_pkg::DLEN_W) ? AW : fed_pkg::DLEN_W;
    localparam int SW    = fed_pkg::SAMPLE_W;

    localparam logic [LW-1:0] DLY_MAX = LW'(MAX_DELAY - 1);
    localparam logic [fed_pkg::DLEN_W-1:0] DLY_RST =
        (fed_pkg::DELAY_RST > MAX_DELAY - 1) ? fed_pkg::DLEN_W'(MAX_DELAY - 1)
                                             : fed_pkg::DLEN_W'(fed_pkg::DELAY_RST);

    typedef struct packed {
        logic                 valid;
        logic                 chan;
        logic signed [SW-1:0] x;
        logic [MW-1:0]        waddr;
        logic                 rd_ok;
        logic                 fwd;
        logic signed [SW-1:0] fwd_data;
    } t_s1;

    typedef struct packed {
        logic                              valid;
        logic                              chan;
        logic signed [SW-1:0]              x;
        logic [MW-1:0]                     waddr;
        logic signed [fed_pkg::PROD_W-1:0] p_fb;
        logic signed [fed_pkg::PROD_W-1:0] p_dry;
        logic signed [fed_pkg::PROD_W-1:0] p_wet;
    } t_s2;

    // configuration registers
    logic [fed_pkg::DLEN_W-1:0] r_delay_len;
    logic [fed_pkg::GAIN_W-1:0] r_fb_gain;
    logic [fed_pkg::MIX_W-1:0]  r_mix;

    // per-channel write pointers and wrap flags
    logic [AW-1:0]           r_wp [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_wrap;

    // delay store
    logic signed [SW-1:0] mem [DEPTH];
    logic signed [SW-1:0] r_rd_data;

    // pipeline
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    logic                 r_out_valid;
    logic                 r_out_chan;
    logic signed [SW-1:0] r_out_data;

    logic                 cfg_wr;
    logic [CW-1:0]        ch;
    logic [AW-1:0]        wp;
    logic [AW-1:0]        n_wp;
    logic [LW-1:0]        rp_full;
    logic [AW-1:0]        rp;
    logic [MW-1:0]        raddr;
    logic [MW-1:0]        waddr;
    logic                 hz;
    logic                 accept;
    logic                 adv_out;
    logic                 s2_free;
    logic                 s1_free;
    logic signed [SW-1:0] delayed;
    logic signed [fed_pkg::ACC_W-1:0] acc_fb;
    logic signed [fed_pkg::ACC_W-1:0] acc_y;
    logic signed [SW-1:0] fb_val;
    logic signed [SW-1:0] y_val;
    logic [fed_pkg::DLEN_W-1:0] wr_dlen;
    logic [fed_pkg::GAIN_W-1:0] wr_fb;
    logic [fed_pkg::MIX_W-1:0]  wr_mix;

    // register port write with clamping
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign wr_dlen = pwdata[fed_pkg::DLEN_W-1:0];
    assign wr_fb   = pwdata[fed_pkg::GAIN_W-1:0];
    assign wr_mix  = pwdata[fed_pkg::MIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_len <= DLY_RST;
            r_fb_gain   <= fed_pkg::FB_RST;
            r_mix       <= fed_pkg::MIX_RST;
        end else if (cfg_wr) begin
            unique case (fed_pkg::t_reg_idx'(paddr[3:2]))
                fed_pkg::REG_DELAY: begin
                    if (wr_dlen == '0) begin
                        r_delay_len <= fed_pkg::DLEN_W'(1);
                    end else if (LW'(wr_dlen) > DLY_MAX) begin
                        r_delay_len <= DLY_MAX[fed_pkg::DLEN_W-1:0];
                    end else begin
                        r_delay_len <= wr_dlen;
                    end
                end
                fed_pkg::REG_FEEDBACK: begin
                    r_fb_gain <= (wr_fb > fed_pkg::FB_CEIL) ? fed_pkg::FB_CEIL : wr_fb;
                end
                fed_pkg::REG_MIX: begin
                    r_mix <= (wr_mix > fed_pkg::MIX_ONE) ? fed_pkg::MIX_ONE : wr_mix;
                end
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (fed_pkg::t_reg_idx'(paddr[3:2]))
            fed_pkg::REG_DELAY:    prdata = 32'(r_delay_len);
            fed_pkg::REG_FEEDBACK: prdata = 32'(r_fb_gain);
            fed_pkg::REG_MIX:      prdata = 32'(r_mix);
            default:               prdata = '0;
        endcase
    end

    // pipeline flow control
    assign adv_out = r_s2.valid && (!r_out_valid || i_m_axis_tready);
    assign s2_free = !r_s2.valid || adv_out;
    assign s1_free = !r_s1.valid || s2_free;

    // read address: write pointer minus delay, modulo the line length
    assign ch      = (NUM_CHANNELS > 1) ? CW'(i_s_axis_tuser[0]) : '0;
    assign wp      = r_wp[ch];
    assign n_wp    = (wp == AW'(MAX_DELAY - 1)) ? '0 : wp + AW'(1);
    assign rp_full = (LW'(wp) >= LW'(r_delay_len))
                   ? LW'(wp) - LW'(r_delay_len)
                   : LW'(wp) + LW'(MAX_DELAY) - LW'(r_delay_len);
    assign rp      = rp_full[AW-1:0];
    assign raddr   = MW'(ch) * MW'(MAX_DELAY) + MW'(rp);
    assign waddr   = MW'(ch) * MW'(MAX_DELAY) + MW'(wp);

    // interlock: entry still to be written by an item that is not yet at write-back
    assign hz = (r_s1.valid && r_s1.waddr == raddr)
             || (r_s2.valid && !adv_out && r_s2.waddr == raddr);

    assign o_s_axis_tready = s1_free && !hz;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // write pointers and wrap flags advance per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_wp[i] <= '0;
            end
            r_wrap <= '0;
        end else if (accept) begin
            r_wp[ch] <= n_wp;
            if (wp == AW'(MAX_DELAY - 1)) begin
                r_wrap[ch] <= 1'b1;
            end
        end
    end

    // stage 1 capture, forwarding the write that lands on the same edge
    always_comb begin
        n_s1.valid    = accept;
        n_s1.chan     = i_s_axis_tuser[0];
        n_s1.x        = $signed(i_s_axis_tdata[SW-1:0]);
        n_s1.waddr    = waddr;
        n_s1.rd_ok    = r_wrap[ch] || (rp < wp);
        n_s1.fwd      = adv_out && (r_s2.waddr == raddr);
        n_s1.fwd_data = fb_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (s1_free) begin
            r_s1 <= n_s1;
        end
    end

    // delay store: read on request, write back on result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= mem[raddr];
        end
        if (adv_out) begin
            mem[r_s2.waddr] <= fb_val;
        end
    end

    // stage 2: gain products
    always_comb begin
        if (r_s1.fwd) begin
            delayed = r_s1.fwd_data;
        end else if (r_s1.rd_ok) begin
            delayed = r_rd_data;
        end else begin
            delayed = '0;
        end
        n_s2.valid = r_s1.valid;
        n_s2.chan  = r_s1.chan;
        n_s2.x     = r_s1.x;
        n_s2.waddr = r_s1.waddr;
        n_s2.p_fb  = fed_pkg::PROD_W'(delayed)
                   * fed_pkg::PROD_W'($signed({1'b0, r_fb_gain}));
        n_s2.p_dry = fed_pkg::PROD_W'(r_s1.x)
                   * fed_pkg::PROD_W'($signed({1'b0, fed_pkg::MIX_ONE - r_mix}));
        n_s2.p_wet = fed_pkg::PROD_W'(delayed)
                   * fed_pkg::PROD_W'($signed({1'b0, r_mix}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (s2_free) begin
            r_s2 <= n_s2;
        end
    end

    // feedback write-back value and mixed output
    assign acc_fb = (fed_pkg::ACC_W'(r_s2.x) <<< 16) + fed_pkg::ACC_W'(r_s2.p_fb);
    assign acc_y  = fed_pkg::ACC_W'(r_s2.p_dry) + fed_pkg::ACC_W'(r_s2.p_wet);
    assign fb_val = $signed(fed_pkg::q16_round_sat(acc_fb));
    assign y_val  = $signed(fed_pkg::q16_round_sat(acc_y));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out_chan <= r_s2.chan;
            r_out_data <= y_val;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_chan;

    // checks
    a_delay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_delay_len != '0) && (LW'(r_delay_len) <= DLY_MAX))
        else $error("delay length out of range");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fb_gain <= fed_pkg::FB_CEIL) && (r_mix <= fed_pkg::MIX_ONE))
        else $error("gain register beyond its ceiling");

    a_no_addr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1.valid && r_s2.valid && r_s1.waddr == r_s2.waddr))
        else $error("two items in flight write the same entry");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp[0] <= AW'(MAX_DELAY - 1))
        else $error("write pointer past line length");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_out |=> o_m_axis_tvalid)
        else $error("write-back without output request");

endmodule

// ===== sim/tb_feedback_echo_delay.sv =====
// ----------------------------------------------------------------------------
// tb_feedback_echo_delay: self-checking bench for the feedback echo delay
// Drives sample requests on the input stream and register writes on the apb
// port, predicts each mixed output with a fixed-point echo model of its own,
// and compares every output request with the oldest prediction.
// Random idling on both streams; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb_feedback_echo_delay;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH          = 131072;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASES         = 16;
    localparam int         PHASE_ITEMS    = 64;
    localparam logic [3:0] ADDR_UNUSED    = 4'd12;
    localparam longint     S_MAX          = 64'sd8388607;
    localparam longint     S_MIN          = -64'sd8388608;

    typedef struct packed {
        logic [0:0]  chan;
        logic [23:0] sample;
    } t_echo_out;

    // clock, reset and block inputs
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    // block outputs
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic [31:0] prdata;
    logic        pready;

    // echo model state and register copies
    bit signed [23:0] echo_mem [2][DEPTH];
    int unsigned      wr_pos [2];
    int               dly_len = fed_pkg::DELAY_RST;
    int               fb_gain = int'(fed_pkg::FB_RST);
    int               mix_lvl = int'(fed_pkg::MIX_RST);

    t_echo_out echo_expected[$];
    int        err_cnt     = 0;
    int        idle_cycles = 0;
    bit        stall_en    = 1'b1;

    feedback_echo_delay i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // clamp to the signed 24-bit sample range
    function automatic longint sat_sample(input longint v);
        if (v > S_MAX) begin
            return S_MAX;
        end
        if (v < S_MIN) begin
            return S_MIN;
        end
        return v;
    endfunction

    // divide by 2^16 with round half up
    function automatic longint q16_round(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    // one echo step: read the tap, write back with feedback, mix dry and wet
    function automatic logic [23:0] echo_predict(input logic [0:0] ch,
                                                 input logic signed [23:0] smp);
        longint      dry;
        longint      tap;
        longint      fbv;
        longint      wet_mix;
        int unsigned wp;
        int unsigned rp;
        dry = smp;
        wp  = wr_pos[ch];
        rp  = (wp + DEPTH - dly_len) % DEPTH;
        tap = echo_mem[ch][rp];
        fbv = sat_sample(dry + q16_round(tap * fb_gain));
        echo_mem[ch][wp] = fbv[23:0];
        wr_pos[ch] = (wp + 1) % DEPTH;
        wet_mix = sat_sample(q16_round(dry * (int'(fed_pkg::MIX_ONE) - mix_lvl)
                                       + tap * mix_lvl));
        return wet_mix[23:0];
    endfunction

    // register value as the block should hold it
    function automatic int reg_model(input fed_pkg::t_reg_idx idx);
        case (idx)
            fed_pkg::REG_DELAY:    return dly_len;
            fed_pkg::REG_FEEDBACK: return fb_gain;
            fed_pkg::REG_MIX:      return mix_lvl;
            default:               return 0;
        endcase
    endfunction

    // apb write: setup cycle, access cycle, then idle
    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write a register and track the clamped value
    task automatic reg_write(input fed_pkg::t_reg_idx idx, input logic [31:0] data);
        int v;
        apb_write({idx, 2'b00}, data);
        case (idx)
            fed_pkg::REG_DELAY: begin
                v = int'(data & 32'h1FFFF);
                dly_len = (v < 1) ? 1 : ((v > DEPTH - 1) ? DEPTH - 1 : v);
            end
            fed_pkg::REG_FEEDBACK: begin
                v = int'(data & 32'hFFFF);
                fb_gain = (v > int'(fed_pkg::FB_CEIL)) ? int'(fed_pkg::FB_CEIL) : v;
            end
            fed_pkg::REG_MIX: begin
                v = int'(data & 32'h1FFFF);
                mix_lvl = (v > int'(fed_pkg::MIX_ONE)) ? int'(fed_pkg::MIX_ONE) : v;
            end
            default: begin
            end
        endcase
    endtask

    // apb read and compare with the tracked value
    task automatic reg_check(input fed_pkg::t_reg_idx idx);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== 32'(reg_model(idx))) begin
            err_cnt++;
            $error("%s readback mismatch: expected %0d, got %0d",
                   idx.name(), reg_model(idx), got);
        end
    endtask

    // one sample request; tvalid stays high for a following request
    task automatic send_sample(input logic [0:0] ch, input logic [23:0] smp);
        while (stall_en && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= ch;
        do @(posedge clk); while (!s_tready);
        echo_expected.push_back('{chan: ch, sample: echo_predict(ch, smp)});
    endtask

    // stop sending and wait for every predicted output
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (echo_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // reset values, then samples that only meet unwritten entries of the store
    task automatic test_reset_state();
        reg_check(fed_pkg::REG_DELAY);
        reg_check(fed_pkg::REG_FEEDBACK);
        reg_check(fed_pkg::REG_MIX);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        send_sample(1'b0, 24'h000001);
        send_sample(1'b1, 24'hFFFFFF);
        drain_results();
    endtask

    // clamping, masking of unused bits and a write outside the map
    task automatic test_register_clamps();
        reg_write(fed_pkg::REG_DELAY, 32'd0);
        reg_check(fed_pkg::REG_DELAY);
        reg_write(fed_pkg::REG_DELAY, 32'hFFFF_FFFF);
        reg_check(fed_pkg::REG_DELAY);
        reg_write(fed_pkg::REG_DELAY, 32'h0002_0005);
        reg_check(fed_pkg::REG_DELAY);
        reg_write(fed_pkg::REG_FEEDBACK, 32'd65535);
        reg_check(fed_pkg::REG_FEEDBACK);
        reg_write(fed_pkg::REG_FEEDBACK, 32'h0001_0005);
        reg_check(fed_pkg::REG_FEEDBACK);
        reg_write(fed_pkg::REG_FEEDBACK, 32'd62259);
        reg_check(fed_pkg::REG_FEEDBACK);
        reg_write(fed_pkg::REG_MIX, 32'd65537);
        reg_check(fed_pkg::REG_MIX);
        reg_write(fed_pkg::REG_MIX, 32'h0001_FFFF);
        reg_check(fed_pkg::REG_MIX);
        reg_write(fed_pkg::REG_MIX, 32'd0);
        reg_check(fed_pkg::REG_MIX);
        // unmapped address must leave every register alone
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        reg_check(fed_pkg::REG_DELAY);
        reg_check(fed_pkg::REG_FEEDBACK);
        reg_check(fed_pkg::REG_MIX);
    endtask

    // shortest delay with the strongest feedback drives the loop into saturation
    task automatic test_feedback_saturation();
        reg_write(fed_pkg::REG_DELAY, 32'd0);
        reg_write(fed_pkg::REG_FEEDBACK, 32'd65535);
        reg_write(fed_pkg::REG_MIX, 32'd65536);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h000010);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'hFFFFF0);
        send_sample(1'b0, 24'h800000);
        send_sample(1'b0, 24'h800000);
        send_sample(1'b0, 24'h800000);
        drain_results();
        // dry only, then fully wet from the far end of the store
        reg_write(fed_pkg::REG_MIX, 32'd0);
        send_sample(1'b0, 24'h123456);
        send_sample(1'b1, 24'hEDCBA9);
        drain_results();
        reg_write(fed_pkg::REG_DELAY, 32'd131071);
        reg_write(fed_pkg::REG_MIX, 32'd65536);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        drain_results();
    endtask

    // delay picks: mostly short so that feedback builds up
    function automatic logic [31:0] pick_delay();
        case ($urandom_range(11))
            0:       return 32'd1;
            1:       return 32'd2;
            2:       return 32'd131071;
            3:       return 32'd0;
            4:       return $urandom();
            5:       return 32'hFFFF_FFFF;
            default: return $urandom_range(40, 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_feedback();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd62259;
            2:       return 32'd65535;
            3:       return $urandom();
            default: return $urandom_range(62259, 30000);
        endcase
    endfunction

    function automatic logic [31:0] pick_mix();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd65536;
            2:       return 32'd131071;
            3:       return $urandom();
            default: return $urandom_range(65536);
        endcase
    endfunction

    function automatic logic [23:0] pick_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'(int'($urandom_range(255)) - 128);
            default: return r[23:0];
        endcase
    endfunction

    // phases of random settings, one stretch without idling on either side
    task automatic test_random_traffic();
        logic [0:0] ch;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            stall_en <= !(phase >= 6 && phase <= 8);
            reg_write(fed_pkg::REG_DELAY, pick_delay());
            reg_write(fed_pkg::REG_FEEDBACK, pick_feedback());
            reg_write(fed_pkg::REG_MIX, pick_mix());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // every fourth phase stays on one channel to press short delays
                ch = (phase % 4 == 0) ? 1'b0 : 1'($urandom_range(1));
                send_sample(ch, pick_sample());
            end
        end
        drain_results();
        stall_en <= 1'b1;
    endtask

    // output side: random stalls, result checking and the watchdog
    always @(posedge clk) begin
        t_echo_out want;
        if (!rst_n) begin
            m_tready    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (echo_expected.size() == 0) begin
                    err_cnt++;
                    $error("output request with no prediction: chan_out %0d sample_out %0d",
                           m_tuser, $signed(m_tdata));
                end else begin
                    want = echo_expected.pop_front();
                    if (m_tuser !== want.chan) begin
                        err_cnt++;
                        $error("chan_out mismatch: expected %0d, got %0d", want.chan, m_tuser);
                    end
                    if (m_tdata !== want.sample) begin
                        err_cnt++;
                        $error("sample_out mismatch: expected %0d, got %0d",
                               $signed(want.sample), $signed(m_tdata));
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_feedback_echo_delay NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            m_tready <= !(stall_en && $urandom_range(99) < 7);
        end
    end

    // test sequence
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_register_clamps();
        test_feedback_saturation();
        test_random_traffic();
        repeat (10) @(posedge clk);
        if (err_cnt == 0) begin
            $display("tb_feedback_echo_delay OK");
        end else begin
            $display("tb_feedback_echo_delay NOT OK");
        end
        $finish;
    end

endmodule
